// ===== hdl/lsu8_pkg.sv =====
// Shared types, codes and the mode decode table of the 8-bit load/store unit.
// Used by lsu8_mem and load_store_unit_8bit; depends on nothing.
`default_nettype none
package lsu8_pkg;

  localparam int MEM_DEPTH = 65536;
  localparam int MEM_AW = $clog2(MEM_DEPTH);

  localparam logic [2:0] OP_LDA  = 3'd0;
  localparam logic [2:0] OP_LDX  = 3'd1;
  localparam logic [2:0] OP_LDY  = 3'd2;
  localparam logic [2:0] OP_STA  = 3'd3;
  localparam logic [2:0] OP_STX  = 3'd4;
  localparam logic [2:0] OP_STY  = 3'd5;
  localparam logic [2:0] OP_POKE = 3'd6;

  localparam logic [3:0] AM_IMM  = 4'd0;
  localparam logic [3:0] AM_ZP   = 4'd1;
  localparam logic [3:0] AM_ZPX  = 4'd2;
  localparam logic [3:0] AM_ZPY  = 4'd3;
  localparam logic [3:0] AM_ABS  = 4'd4;
  localparam logic [3:0] AM_ABSX = 4'd5;
  localparam logic [3:0] AM_ABSY = 4'd6;
  localparam logic [3:0] AM_INDX = 4'd7;
  localparam logic [3:0] AM_INDY = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_PTR_LO,
    ST_PTR_HI,
    ST_LOAD
  } state_t;

  function automatic logic [8:0] mode_mask(input logic [2:0] opc);
    logic [8:0] m;
    case (opc)
      OP_LDA:  m = 9'b1_1111_0111;
      OP_LDX:  m = 9'b0_0101_1011;
      OP_LDY:  m = 9'b0_0011_0111;
      OP_STA:  m = 9'b1_1111_0110;
      OP_STX:  m = 9'b0_0001_1010;
      OP_STY:  m = 9'b0_0001_0110;
      default: m = 9'b0_0000_0000;
    endcase
    return m;
  endfunction

  function automatic logic mode_ok(input logic [2:0] opc, input logic [3:0] mode);
    logic [8:0] m;
    m = mode_mask(opc);
    if (mode > AM_INDY) return 1'b0;
    return m[mode];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lsu8_mem.sv =====
// Byte-wide single-port synchronous memory with a registered read, read-first.
// Depends on lsu8_pkg for MEM_DEPTH and MEM_AW.
`default_nettype none
module lsu8_mem
  import lsu8_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [MEM_AW-1:0] addr,
  input  wire logic              we,
  input  wire logic [7:0]        wdata,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== hdl/load_store_unit_8bit.sv =====
// Top level of the 8-bit load/store unit: sequencer, register file and flags.
// Depends on lsu8_pkg and instantiates lsu8_mem.
//
// Channel   Direction  Handshake                 Fields
// request   in         start && !busy            opcode addr_mode operand poke_data
// result    out        done (one cycle strobe)   reg_a reg_x reg_y flag_n flag_z
//                                                did_write write_addr write_data bad_mode
//
// A request goes from IDLE to ISSUE, where pokes, bad modes, immediate loads and
// direct stores end; other loads go on to LOAD, indirect modes pass PTR_LO, PTR_HI
// first, for the registered reads on the single memory port. A new request is taken in
// the cycle done is high. Reset clears registers, flags and the sequencer; memory is not
// cleared. The result receiver cannot stall. Memory depth must be a power of two.
`default_nettype none
module load_store_unit_8bit
  import lsu8_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode,
  input  wire logic [3:0]  addr_mode,
  input  wire logic [15:0] operand,
  input  wire logic [7:0]  poke_data,
  output logic             done,
  output logic      [7:0]  reg_a,
  output logic      [7:0]  reg_x,
  output logic      [7:0]  reg_y,
  output logic             flag_n,
  output logic             flag_z,
  output logic             did_write,
  output logic      [15:0] write_addr,
  output logic      [7:0]  write_data,
  output logic             bad_mode
);

  state_t state, state_next;
  logic [2:0]  opc_q;
  logic [3:0]  mode_q;
  logic [15:0] oper_q;
  logic [7:0]  pdata_q;
  logic [7:0]  ptr_lo, ptr_lo_next;

  logic [7:0]  reg_a_next, reg_x_next, reg_y_next;
  logic        flag_n_next, flag_z_next, done_next, did_write_next, bad_mode_next;
  logic [15:0] write_addr_next;
  logic [7:0]  write_data_next;

  logic [15:0] mem_addr;
  logic        mem_we;
  logic [7:0]  mem_wdata, mem_rdata;

  logic [7:0]  lo8, zp_ptr, load_val, store_val;
  logic [15:0] direct_ea, ptr_ea, ea;
  logic        is_load, is_indirect;

  lsu8_mem u_mem (
    .clk   (clk),
    .addr  (mem_addr[MEM_AW-1:0]),
    .we    (mem_we),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign busy = (state != ST_IDLE);

  always_comb begin
    lo8 = oper_q[7:0];
    zp_ptr = (mode_q == AM_INDX) ? lo8 + reg_x : lo8;
    case (mode_q)
      AM_ZPX:  direct_ea = {8'h00, 8'(lo8 + reg_x)};
      AM_ZPY:  direct_ea = {8'h00, 8'(lo8 + reg_y)};
      AM_ABS:  direct_ea = oper_q;
      AM_ABSX: direct_ea = oper_q + {8'h00, reg_x};
      AM_ABSY: direct_ea = oper_q + {8'h00, reg_y};
      default: direct_ea = {8'h00, lo8};
    endcase
    ptr_ea = {mem_rdata, ptr_lo} + ((mode_q == AM_INDY) ? {8'h00, reg_y} : 16'h0000);
    ea = (state == ST_PTR_HI) ? ptr_ea : direct_ea;
    case (opc_q)
      OP_STA:  store_val = reg_a;
      OP_STX:  store_val = reg_x;
      default: store_val = reg_y;
    endcase
    load_val = (state == ST_LOAD) ? mem_rdata : lo8;
    is_load = (opc_q == OP_LDA) || (opc_q == OP_LDX) || (opc_q == OP_LDY);
    is_indirect = (mode_q == AM_INDX) || (mode_q == AM_INDY);
  end

  always_comb begin
    state_next = state;
    ptr_lo_next = ptr_lo;
    reg_a_next = reg_a;
    reg_x_next = reg_x;
    reg_y_next = reg_y;
    flag_n_next = flag_n;
    flag_z_next = flag_z;
    done_next = 1'b0;
    did_write_next = did_write;
    write_addr_next = write_addr;
    write_data_next = write_data;
    bad_mode_next = bad_mode;
    mem_addr = ea;
    mem_we = 1'b0;
    mem_wdata = store_val;

    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        did_write_next = 1'b0;
        write_addr_next = 16'h0000;
        write_data_next = 8'h00;
        bad_mode_next = 1'b0;
        if (opc_q == OP_POKE) begin
          mem_addr = oper_q;
          mem_we = 1'b1;
          mem_wdata = pdata_q;
          did_write_next = 1'b1;
          write_addr_next = oper_q;
          write_data_next = pdata_q;
          done_next = 1'b1;
          state_next = ST_IDLE;
        end else if (!mode_ok(opc_q, mode_q)) begin
          bad_mode_next = 1'b1;
          done_next = 1'b1;
          state_next = ST_IDLE;
        end else if (is_indirect) begin
          mem_addr = {8'h00, zp_ptr};
          state_next = ST_PTR_LO;
        end else if (is_load && mode_q != AM_IMM) begin
          state_next = ST_LOAD;
        end else if (is_load) begin
          state_next = ST_LOAD;
        end else begin
          mem_we = 1'b1;
          did_write_next = 1'b1;
          write_addr_next = ea;
          write_data_next = store_val;
          done_next = 1'b1;
          state_next = ST_IDLE;
        end
        if (is_load && mode_q == AM_IMM && opc_q != OP_POKE) begin
          case (opc_q)
            OP_LDA:  reg_a_next = load_val;
            OP_LDX:  reg_x_next = load_val;
            default: reg_y_next = load_val;
          endcase
          flag_n_next = load_val[7];
          flag_z_next = (load_val == 8'h00);
          done_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_PTR_LO: begin
        ptr_lo_next = mem_rdata;
        mem_addr = {8'h00, 8'(zp_ptr + 8'd1)};
        state_next = ST_PTR_HI;
      end
      ST_PTR_HI: begin
        if (is_load) begin
          state_next = ST_LOAD;
        end else begin
          mem_we = 1'b1;
          did_write_next = 1'b1;
          write_addr_next = ea;
          write_data_next = store_val;
          done_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_LOAD: begin
        case (opc_q)
          OP_LDA:  reg_a_next = load_val;
          OP_LDX:  reg_x_next = load_val;
          default: reg_y_next = load_val;
        endcase
        flag_n_next = load_val[7];
        flag_z_next = (load_val == 8'h00);
        done_next = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
      reg_a <= 8'h00;
      reg_x <= 8'h00;
      reg_y <= 8'h00;
      flag_n <= 1'b0;
      flag_z <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
      reg_a <= reg_a_next;
      reg_x <= reg_x_next;
      reg_y <= reg_y_next;
      flag_n <= flag_n_next;
      flag_z <= flag_z_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      opc_q <= opcode;
      mode_q <= addr_mode;
      oper_q <= operand;
      pdata_q <= poke_data;
    end
    ptr_lo <= ptr_lo_next;
    did_write <= did_write_next;
    write_addr <= write_addr_next;
    write_data <= write_data_next;
    bad_mode <= bad_mode_next;
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for load_store_unit_8bit: directed table, then random requests
// checked against an in-bench model of registers, flags and a 64K byte memory.
// Depends on lsu8_pkg for the opcode and addressing mode codes.
module tb_top;
  import lsu8_pkg::*;

  localparam int STALL_LIMIT = 200;
  localparam int RANDOM_PER_PHASE = 420;

  localparam logic [15:0] B_IMM  = 16'd1 << AM_IMM;
  localparam logic [15:0] B_ZP   = 16'd1 << AM_ZP;
  localparam logic [15:0] B_ZPX  = 16'd1 << AM_ZPX;
  localparam logic [15:0] B_ZPY  = 16'd1 << AM_ZPY;
  localparam logic [15:0] B_ABS  = 16'd1 << AM_ABS;
  localparam logic [15:0] B_ABSX = 16'd1 << AM_ABSX;
  localparam logic [15:0] B_ABSY = 16'd1 << AM_ABSY;
  localparam logic [15:0] B_INDX = 16'd1 << AM_INDX;
  localparam logic [15:0] B_INDY = 16'd1 << AM_INDY;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  mode;
    logic [15:0] operand;
    logic [7:0]  pdata;
  } lsu_req_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        n;
    logic        z;
    logic        wr;
    logic [15:0] waddr;
    logic [7:0]  wdata;
    logic        bad;
  } lsu_res_t;

  typedef struct packed {
    lsu_req_t req;
    logic     typed;
    lsu_res_t res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  opcode;
  logic [3:0]  addr_mode;
  logic [15:0] operand;
  logic [7:0]  poke_data;
  logic        done;
  logic [7:0]  reg_a;
  logic [7:0]  reg_x;
  logic [7:0]  reg_y;
  logic        flag_n;
  logic        flag_z;
  logic        did_write;
  logic [15:0] write_addr;
  logic [7:0]  write_data;
  logic        bad_mode;

  logic [7:0]  mem_img [MEM_DEPTH];
  bit          mem_set [MEM_DEPTH];
  logic [15:0] hot_addr [$];
  logic [7:0]  cur_a;
  logic [7:0]  cur_x;
  logic [7:0]  cur_y;
  logic        cur_n;
  logic        cur_z;

  lsu_res_t    pending_results [$];
  lsu_res_t    next_result;
  lsu_res_t    got;
  stim_row_t   directed_rows [$];
  int          n_accepted;
  int          n_results;
  int          n_loads;
  int          n_stores;
  int          n_pokes;
  int          n_bad;
  int          errors;
  int          idle_pct;
  int          stall_cycles;
  int          goal;

  load_store_unit_8bit i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .addr_mode  (addr_mode),
    .operand    (operand),
    .poke_data  (poke_data),
    .done       (done),
    .reg_a      (reg_a),
    .reg_x      (reg_x),
    .reg_y      (reg_y),
    .flag_n     (flag_n),
    .flag_z     (flag_z),
    .did_write  (did_write),
    .write_addr (write_addr),
    .write_data (write_data),
    .bad_mode   (bad_mode)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit legal_mode(input logic [2:0] opc, input logic [3:0] mode);
    logic [15:0] ok;
    case (opc)
      OP_LDA:  ok = B_IMM | B_ZP | B_ZPX | B_ABS | B_ABSX | B_ABSY | B_INDX | B_INDY;
      OP_LDX:  ok = B_IMM | B_ZP | B_ZPY | B_ABS | B_ABSY;
      OP_LDY:  ok = B_IMM | B_ZP | B_ZPX | B_ABS | B_ABSX;
      OP_STA:  ok = B_ZP | B_ZPX | B_ABS | B_ABSX | B_ABSY | B_INDX | B_INDY;
      OP_STX:  ok = B_ZP | B_ZPY | B_ABS;
      OP_STY:  ok = B_ZP | B_ZPX | B_ABS;
      default: ok = 16'h0000;
    endcase
    return ok[mode];
  endfunction

  function automatic logic [7:0] mem_rd(input logic [15:0] addr);
    return mem_img[addr[MEM_AW-1:0]];
  endfunction

  function automatic void mem_wr(input logic [15:0] addr, input logic [7:0] v);
    mem_img[addr[MEM_AW-1:0]] = v;
    mem_set[addr[MEM_AW-1:0]] = 1'b1;
    hot_addr.push_back(addr);
    if (hot_addr.size() > 32) void'(hot_addr.pop_front());
  endfunction

  function automatic logic [15:0] eff_addr(input logic [3:0] mode, input logic [15:0] opnd);
    logic [7:0]  lo;
    logic [7:0]  zpx;
    logic [7:0]  zpy;
    logic [7:0]  zpi;
    logic [7:0]  zpn;
    logic [15:0] ptr;
    lo = opnd[7:0];
    zpx = lo + cur_x;
    zpy = lo + cur_y;
    zpi = (mode == AM_INDX) ? zpx : lo;
    zpn = zpi + 8'd1;
    ptr = {mem_rd({8'h00, zpn}), mem_rd({8'h00, zpi})};
    case (mode)
      AM_ZP:   return {8'h00, lo};
      AM_ZPX:  return {8'h00, zpx};
      AM_ZPY:  return {8'h00, zpy};
      AM_ABS:  return opnd;
      AM_ABSX: return opnd + {8'h00, cur_x};
      AM_ABSY: return opnd + {8'h00, cur_y};
      AM_INDX: return ptr;
      AM_INDY: return ptr + {8'h00, cur_y};
      default: return 16'h0000;
    endcase
  endfunction

  function automatic lsu_res_t lsu_execute(input lsu_req_t r);
    lsu_res_t    o;
    logic [7:0]  v;
    logic [15:0] ea;
    o = '0;
    if (r.opcode == OP_POKE) begin
      mem_wr(r.operand, r.pdata);
      o.wr = 1'b1;
      o.waddr = r.operand;
      o.wdata = r.pdata;
      n_pokes++;
    end else if (!legal_mode(r.opcode, r.mode)) begin
      o.bad = 1'b1;
      n_bad++;
    end else begin
      ea = eff_addr(r.mode, r.operand);
      if (r.opcode <= OP_LDY) begin
        v = (r.mode == AM_IMM) ? r.operand[7:0] : mem_rd(ea);
        case (r.opcode)
          OP_LDA:  cur_a = v;
          OP_LDX:  cur_x = v;
          default: cur_y = v;
        endcase
        cur_n = v[7];
        cur_z = (v == 8'h00);
        n_loads++;
      end else begin
        case (r.opcode)
          OP_STA:  v = cur_a;
          OP_STX:  v = cur_x;
          default: v = cur_y;
        endcase
        mem_wr(ea, v);
        o.wr = 1'b1;
        o.waddr = ea;
        o.wdata = v;
        n_stores++;
      end
    end
    o.a = cur_a;
    o.x = cur_x;
    o.y = cur_y;
    o.n = cur_n;
    o.z = cur_z;
    return o;
  endfunction

  function automatic logic [15:0] pick_operand();
    logic [7:0] lo;
    logic [7:0] page;
    lo = 8'($urandom());
    case ($urandom_range(0, 4))
      0: return 16'($urandom());
      1: return {8'h00, lo};
      2: begin
        if (hot_addr.size() == 0) return {8'hFF, lo};
        return hot_addr[$urandom_range(0, hot_addr.size() - 1)];
      end
      3: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'h00FF;
          default: return 16'hFF00;
        endcase
      end
      default: begin
        case ($urandom_range(0, 2))
          0: page = 8'h01;
          1: page = 8'h80;
          default: page = 8'hFF;
        endcase
        return {page, lo};
      end
    endcase
  endfunction

  task automatic add_row(input logic [2:0] opc, input logic [3:0] mode,
                         input logic [15:0] opnd, input logic [7:0] pdata,
                         input logic typed, input lsu_res_t res);
    stim_row_t row;
    row.req = {opc, mode, opnd, pdata};
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endtask

  // Drives one request at a falling edge and returns at the falling edge after it is taken.
  task automatic issue(input lsu_req_t r, input logic typed, input lsu_res_t typed_res);
    lsu_res_t pred;
    int       target;
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    pred = lsu_execute(r);
    next_result = typed ? typed_res : pred;
    target = n_accepted + 1;
    opcode = r.opcode;
    addr_mode = r.mode;
    operand = r.operand;
    poke_data = r.pdata;
    start = 1'b1;
    do @(negedge clk); while (n_accepted != target);
  endtask

  task automatic poke_if_unset(input logic [15:0] addr);
    lsu_req_t p;
    if (!mem_set[addr[MEM_AW-1:0]]) begin
      p.opcode = OP_POKE;
      p.mode = 4'($urandom());
      p.operand = addr;
      p.pdata = 8'($urandom());
      issue(p, 1'b0, '0);
    end
  endtask

  // Memory bytes a request will read are preloaded first, so no read hits an unwritten byte.
  task automatic fill_reads(input lsu_req_t r);
    logic [7:0] zp;
    if (r.opcode == OP_POKE || !legal_mode(r.opcode, r.mode) || r.mode == AM_IMM) return;
    if (r.mode == AM_INDX || r.mode == AM_INDY) begin
      zp = (r.mode == AM_INDX) ? r.operand[7:0] + cur_x : r.operand[7:0];
      poke_if_unset({8'h00, zp});
      zp = zp + 8'd1;
      poke_if_unset({8'h00, zp});
    end
    if (r.opcode <= OP_LDY) poke_if_unset(eff_addr(r.mode, r.operand));
  endtask

  task automatic random_request();
    lsu_req_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    r.operand = pick_operand();
    r.pdata = 8'($urandom());
    if (pick < 10) begin
      r.opcode = 3'($urandom());
      r.mode = 4'($urandom());
    end else if (pick < 25) begin
      r.opcode = OP_POKE;
      r.mode = 4'($urandom());
    end else begin
      r.opcode = 3'($urandom_range(OP_LDA, OP_STY));
      do r.mode = 4'($urandom_range(AM_IMM, AM_INDY)); while (!legal_mode(r.opcode, r.mode));
    end
    fill_reads(r);
    issue(r, 1'b0, '0);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        n_results++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding", $time);
        end else begin
          got = pending_results.pop_front();
          check_field("reg_a", 16'(got.a), 16'(reg_a));
          check_field("reg_x", 16'(got.x), 16'(reg_x));
          check_field("reg_y", 16'(got.y), 16'(reg_y));
          check_field("flag_n", 16'(got.n), 16'(flag_n));
          check_field("flag_z", 16'(got.z), 16'(flag_z));
          check_field("did_write", 16'(got.wr), 16'(did_write));
          check_field("write_addr", got.waddr, write_addr);
          check_field("write_data", 16'(got.wdata), 16'(write_data));
          check_field("bad_mode", 16'(got.bad), 16'(bad_mode));
        end
      end
      if (start && !busy) begin
        pending_results.push_back(next_result);
        n_accepted++;
      end
      stall_cycles = (done || (start && !busy)) ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no request or result accepted for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_LDA;
    addr_mode = AM_IMM;
    operand = 16'h0000;
    poke_data = 8'h00;
    next_result = '0;
    cur_a = 8'h00;
    cur_x = 8'h00;
    cur_y = 8'h00;
    cur_n = 1'b0;
    cur_z = 1'b0;
    n_accepted = 0;
    n_results = 0;
    n_loads = 0;
    n_stores = 0;
    n_pokes = 0;
    n_bad = 0;
    errors = 0;
    stall_cycles = 0;
    idle_pct = 27;

    // Error codes, extremes and immediate loads straight after reset have fixed results.
    add_row(OP_STA, AM_IMM, 16'h0000, 8'h00, 1'b1,
            {8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b1});
    add_row(3'h7, AM_INDY + 4'd1, 16'hFFFF, 8'hFF, 1'b1,
            {8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b1});
    add_row(OP_LDA, 4'hF, 16'h1234, 8'h00, 1'b1,
            {8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b1});
    add_row(OP_POKE, AM_IMM, 16'hFFFF, 8'hFF, 1'b1,
            {8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 16'hFFFF, 8'hFF, 1'b0});
    add_row(OP_POKE, 4'hF, 16'h0000, 8'h00, 1'b1,
            {8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 16'h0000, 8'h00, 1'b0});
    add_row(OP_LDX, AM_IMM, 16'h00FF, 8'h00, 1'b1,
            {8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0});
    add_row(OP_LDY, AM_IMM, 16'hFF00, 8'h00, 1'b1,
            {8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 8'h00, 1'b0});
    add_row(OP_LDA, AM_IMM, 16'h7F80, 8'h00, 1'b1,
            {8'h80, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0});
    // Zero-page sums and indirect pointers wrap within page zero; absolute sums wrap at 64K.
    add_row(OP_STA, AM_ZPX, 16'h0001, 8'h00, 1'b0, '0);
    add_row(OP_LDA, AM_ABSX, 16'hFF01, 8'h00, 1'b0, '0);
    add_row(OP_POKE, AM_IMM, 16'h00FF, 8'h34, 1'b0, '0);
    add_row(OP_POKE, AM_IMM, 16'h8034, 8'h00, 1'b0, '0);
    add_row(OP_LDA, AM_INDX, 16'h0000, 8'h00, 1'b0, '0);
    add_row(OP_LDY, AM_IMM, 16'h00CC, 8'h00, 1'b0, '0);
    add_row(OP_POKE, AM_IMM, 16'h8100, 8'h7F, 1'b0, '0);
    add_row(OP_LDA, AM_INDY, 16'h00FF, 8'h00, 1'b0, '0);
    add_row(OP_STX, AM_ZPY, 16'h0040, 8'h00, 1'b0, '0);
    add_row(OP_LDX, AM_ZPY, 16'h0040, 8'h00, 1'b0, '0);
    add_row(OP_STY, AM_ABS, 16'hFFFE, 8'h00, 1'b0, '0);
    add_row(OP_LDX, AM_ABSY, 16'hFF32, 8'h00, 1'b0, '0);
    add_row(OP_STY, AM_ZPX, 16'h0080, 8'h00, 1'b0, '0);
    add_row(OP_LDA, AM_ZP, 16'h004C, 8'h00, 1'b0, '0);
    add_row(OP_STA, AM_INDY, 16'h00FF, 8'h00, 1'b0, '0);
    add_row(OP_STA, AM_ABSY, 16'hFFFF, 8'h00, 1'b0, '0);
    add_row(OP_STX, AM_INDX, 16'h0010, 8'h00, 1'b0, '0);
    add_row(OP_LDY, AM_ZPY, 16'h0010, 8'h00, 1'b0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < directed_rows.size(); i++) begin
      fill_reads(directed_rows[i].req);
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 27 : (ph == 1) ? 49 : 0;
      goal = n_accepted + RANDOM_PER_PHASE;
      while (n_accepted < goal) random_request();
      drain();
    end
    repeat (10) @(negedge clk);

    $display("Requests: %0d loads, %0d stores, %0d pokes, %0d with an unsupported mode",
             n_loads, n_stores, n_pokes, n_bad);
    $display("Results checked: %0d, mismatches: %0d", n_results, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lsu8_pkg.sv
hdl/lsu8_mem.sv
hdl/load_store_unit_8bit.sv
tb/sv/tb_top.sv
